>>> rtl/aff2d_pkg.sv
// Shared types, constants and functions of the 2D affine transform composer.
// Holds the command codes, the queue entry and the quarter-wave sine table contents.
// No dependencies.
package aff2d_pkg;

	localparam int ANGLE_BITS = 12;
	localparam int FRAC_BITS  = 16;

	localparam int DATA_W     = 32;
	localparam int CMD_W      = 2;
	localparam int ANGLE_IN_W = 12;
	localparam int QTR_BITS   = ANGLE_BITS - 2;
	localparam int QUARTER    = 1 << QTR_BITS;
	localparam int SIN_W      = FRAC_BITS + 1;
	localparam int TRIG_W     = FRAC_BITS + 2;
	localparam int PROD_W     = 2 * DATA_W;
	localparam int ADD_W      = DATA_W + 1;
	localparam int ACC_W      = PROD_W + 2;
	localparam int MAT_N      = 6;
	localparam int MAT_ROWS   = MAT_N / 2;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW   = $clog2(QUEUE_DEPTH);

	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic signed [DATA_W-1:0] FX_ONE   = DATA_W'(1) << FRAC_BITS;
	localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << FRAC_BITS;
	localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'({1'b0, {(DATA_W-1){1'b1}}});
	localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

	typedef enum logic [CMD_W-1:0] {
		CMD_SCALE     = 2'd0,
		CMD_ROTATE    = 2'd1,
		CMD_TRANSLATE = 2'd2,
		CMD_POINT     = 2'd3
	} cmd_e;

	typedef struct packed {
		logic [QTR_BITS-1:0] addr;
		logic                one;
		logic                neg;
	} trig_ref_t;

	typedef struct packed {
		cmd_e                       cmd;
		logic signed [DATA_W-1:0]   op_x;
		logic signed [DATA_W-1:0]   op_y;
		logic signed [TRIG_W-1:0]   sin_v;
		logic signed [TRIG_W-1:0]   cos_v;
	} queue_entry_t;

	typedef logic [SIN_W-1:0] sine_rom_t [QUARTER];

	// Quotient by shift and subtract; only used to build the table constants.
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[63:0], n[b]};
			if (rem >= {1'b0, d}) begin
				rem = rem - {1'b0, d};
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// Sine of i/2^ANGLE_BITS turn from a Taylor series in Q2.30, rounded half up.
	function automatic logic [SIN_W-1:0] sine_entry(int unsigned i);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] div;
		longint      sum;
		x = (64'(i) * HALF_PI_Q30 + 64'(QUARTER >> 1)) >> QTR_BITS;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int k = 1; k <= 12; k++) begin
			if (term != 64'd0) begin
				div = 64'(2 * k) * 64'(2 * k + 1);
				term = udiv64((term * x2) >> 30, div);
				if ((k & 1) == 1)
					sum = sum - longint'(term);
				else
					sum = sum + longint'(term);
			end
		end
		if (sum < 0)
			sum = 0;
		return SIN_W'((sum + (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
	endfunction

	function automatic sine_rom_t sine_rom_init();
		sine_rom_t t;
		for (int i = 0; i < QUARTER; i++)
			t[i] = sine_entry(i);
		return t;
	endfunction

	localparam sine_rom_t SINE_ROM = sine_rom_init();

	function automatic trig_ref_t trig_ref(logic [ANGLE_BITS-1:0] a);
		trig_ref_t           t;
		logic [QTR_BITS-1:0] r;
		r = a[QTR_BITS-1:0];
		t.addr = a[QTR_BITS] ? (QTR_BITS'(0) - r) : r;
		t.one = a[QTR_BITS] && (r == '0);
		t.neg = a[ANGLE_BITS-1];
		return t;
	endfunction

	function automatic logic signed [TRIG_W-1:0] trig_value(trig_ref_t t,
			logic [SIN_W-1:0] rd);
		logic signed [TRIG_W-1:0] v;
		v = t.one ? TRIG_ONE : TRIG_W'({1'b0, rd});
		return t.neg ? -v : v;
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_data(logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] c;
		c = v;
		if (v > SAT_HI)
			c = SAT_HI;
		else if (v < SAT_LO)
			c = SAT_LO;
		return c[DATA_W-1:0];
	endfunction

endpackage

>>> rtl/aff2d_if.sv
// Channel interfaces of the transform composer: command requests in, point results out.
// Depends on aff2d_pkg.
interface aff2d_in_if import aff2d_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] scale_x;
	logic signed [DATA_W-1:0] scale_y;
	logic [ANGLE_IN_W-1:0]    angle;
	logic                     counterclockwise;
	logic signed [DATA_W-1:0] shift_x;
	logic signed [DATA_W-1:0] shift_y;
	logic signed [DATA_W-1:0] point_x;
	logic signed [DATA_W-1:0] point_y;

	modport source(output valid, cmd, scale_x, scale_y, angle, counterclockwise,
		shift_x, shift_y, point_x, point_y, input ready);
	modport sink(input valid, cmd, scale_x, scale_y, angle, counterclockwise,
		shift_x, shift_y, point_x, point_y, output ready);
endinterface

interface aff2d_out_if import aff2d_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] result_x;
	logic signed [DATA_W-1:0] result_y;

	modport source(output valid, result_x, result_y, input ready);
	modport sink(input valid, result_x, result_y, output ready);
endinterface

>>> rtl/aff2d_ram.sv
// Generic RAM with one write port and two registered read ports.
// No dependencies.
module aff2d_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end
endmodule

>>> rtl/aff2d_front.sv
// Front end: sine table fill after reset, request intake, angle lookup and operand selection.
// Depends on aff2d_pkg, aff2d_if and aff2d_ram.
module aff2d_front import aff2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	aff2d_in_if.sink     items,
	input  logic         queue_full,
	output logic         push_valid,
	output queue_entry_t push_entry,
	output logic         fill_done
);
	logic [QTR_BITS:0]        fill_q;
	logic                     accept;
	logic [ANGLE_BITS-1:0]    ang_raw;
	logic [ANGLE_BITS-1:0]    ang_sin;
	logic [ANGLE_BITS-1:0]    ang_cos;
	trig_ref_t                ref_sin;
	trig_ref_t                ref_cos;
	logic [SIN_W-1:0]         rd_sin;
	logic [SIN_W-1:0]         rd_cos;
	logic                     f1_valid_q;
	cmd_e                     cmd_s1;
	logic signed [DATA_W-1:0] opx_s1;
	logic signed [DATA_W-1:0] opy_s1;
	trig_ref_t                tsin_s1;
	trig_ref_t                tcos_s1;
	logic signed [DATA_W-1:0] opx_sel;
	logic signed [DATA_W-1:0] opy_sel;

	assign fill_done = fill_q[QTR_BITS];
	assign items.ready = fill_done && (!f1_valid_q || !queue_full);
	assign accept = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_q <= '0;
		else if (!fill_done)
			fill_q <= fill_q + 1'b1;
	end

	assign ang_raw = ANGLE_BITS'(items.angle);
	assign ang_sin = items.counterclockwise ? ang_raw : (ANGLE_BITS'(0) - ang_raw);
	assign ang_cos = ang_sin + ANGLE_BITS'(QUARTER);
	assign ref_sin = trig_ref(ang_sin);
	assign ref_cos = trig_ref(ang_cos);

	aff2d_ram #(
		.WIDTH(SIN_W),
		.DEPTH(QUARTER)
	) u_sine (
		.clk    (clk),
		.we     (!fill_done),
		.waddr  (fill_q[QTR_BITS-1:0]),
		.wdata  (SINE_ROM[fill_q[QTR_BITS-1:0]]),
		.re     (accept),
		.raddr_a(ref_sin.addr),
		.raddr_b(ref_cos.addr),
		.rdata_a(rd_sin),
		.rdata_b(rd_cos)
	);

	always_comb begin
		opx_sel = '0;
		opy_sel = '0;
		case (cmd_e'(items.cmd))
			CMD_SCALE: begin
				opx_sel = items.scale_x;
				opy_sel = items.scale_y;
			end
			CMD_TRANSLATE: begin
				opx_sel = items.shift_x;
				opy_sel = items.shift_y;
			end
			CMD_POINT: begin
				opx_sel = items.point_x;
				opy_sel = items.point_y;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			f1_valid_q <= 1'b0;
		else if (accept)
			f1_valid_q <= 1'b1;
		else if (!queue_full)
			f1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd_e'(items.cmd);
			opx_s1  <= opx_sel;
			opy_s1  <= opy_sel;
			tsin_s1 <= ref_sin;
			tcos_s1 <= ref_cos;
		end
	end

	assign push_valid = f1_valid_q;
	assign push_entry.cmd = cmd_s1;
	assign push_entry.op_x = opx_s1;
	assign push_entry.op_y = opy_s1;
	assign push_entry.sin_v = trig_value(tsin_s1, rd_sin);
	assign push_entry.cos_v = trig_value(tcos_s1, rd_cos);
endmodule

>>> rtl/aff2d_fifo.sv
// Short request queue between the front end and the matrix back end.
// Depends on aff2d_pkg.
module aff2d_fifo import aff2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	input  queue_entry_t push_entry,
	output logic         full,
	input  logic         pop,
	output queue_entry_t head,
	output logic         empty
);
	queue_entry_t        entries_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_q;
	logic [QUEUE_AW-1:0] rd_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                push;

	assign full = (cnt_q == (QUEUE_AW + 1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign push = push_valid && !full;
	assign head = entries_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entries_q[wr_q] <= push_entry;
	end
endmodule

>>> rtl/aff2d_back.sv
// Back end: matrix state, multiply stage, rounding and saturation, result register.
// Depends on aff2d_pkg and aff2d_if.
module aff2d_back import aff2d_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  queue_entry_t head,
	input  logic         queue_empty,
	output logic         pop,
	aff2d_out_if.source  results
);
	logic signed [DATA_W-1:0] m_q [MAT_N];
	logic signed [DATA_W-1:0] opa [MAT_N];
	logic signed [DATA_W-1:0] opb [MAT_N];
	logic signed [DATA_W-1:0] opc [MAT_N];
	logic signed [DATA_W-1:0] opd [MAT_N];
	logic signed [ADD_W-1:0]  add_v [MAT_N];
	logic [MAT_N-1:0]         wen;
	logic signed [PROD_W-1:0] pa_s1 [MAT_N];
	logic signed [PROD_W-1:0] pb_s1 [MAT_N];
	logic signed [ADD_W-1:0]  add_s1 [MAT_N];
	logic [MAT_N-1:0]         wen_s1;
	cmd_e                     cmd_s1;
	logic                     s1_valid_q;
	logic signed [ACC_W-1:0]  acc [MAT_N];
	logic signed [DATA_W-1:0] res [MAT_N];
	logic                     out_free;
	logic                     retire;
	logic                     res_valid_q;
	logic signed [DATA_W-1:0] res_x_q;
	logic signed [DATA_W-1:0] res_y_q;

	assign out_free = !res_valid_q || results.ready;
	assign retire = s1_valid_q && ((cmd_s1 != CMD_POINT) || out_free);
	// A matrix update in flight blocks the next issue until it is written back.
	assign pop = !queue_empty && (!s1_valid_q || (retire && (cmd_s1 == CMD_POINT)));

	always_comb begin
		for (int i = 0; i < MAT_N; i++) begin
			opa[i] = '0;
			opb[i] = '0;
			opc[i] = '0;
			opd[i] = '0;
			add_v[i] = '0;
		end
		wen = '0;
		case (head.cmd)
			CMD_SCALE: begin
				for (int r = 0; r < MAT_ROWS; r++) begin
					opa[2*r] = m_q[2*r];
					opb[2*r] = head.op_x;
					opa[2*r+1] = m_q[2*r+1];
					opb[2*r+1] = head.op_y;
				end
				wen = '1;
			end
			CMD_ROTATE: begin
				for (int r = 0; r < MAT_ROWS; r++) begin
					opa[2*r] = m_q[2*r];
					opb[2*r] = DATA_W'(head.cos_v);
					opc[2*r] = m_q[2*r+1];
					opd[2*r] = DATA_W'(-head.sin_v);
					opa[2*r+1] = m_q[2*r];
					opb[2*r+1] = DATA_W'(head.sin_v);
					opc[2*r+1] = m_q[2*r+1];
					opd[2*r+1] = DATA_W'(head.cos_v);
				end
				wen = '1;
			end
			CMD_TRANSLATE: begin
				add_v[4] = ADD_W'(m_q[4]) + ADD_W'(head.op_x);
				add_v[5] = ADD_W'(m_q[5]) + ADD_W'(head.op_y);
				wen[4] = 1'b1;
				wen[5] = 1'b1;
			end
			CMD_POINT: begin
				opa[0] = head.op_x;
				opb[0] = m_q[0];
				opc[0] = head.op_y;
				opd[0] = m_q[2];
				add_v[0] = ADD_W'(m_q[4]);
				opa[1] = head.op_x;
				opb[1] = m_q[1];
				opc[1] = head.op_y;
				opd[1] = m_q[3];
				add_v[1] = ADD_W'(m_q[5]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (pop)
			s1_valid_q <= 1'b1;
		else if (retire)
			s1_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < MAT_N; i++) begin
				pa_s1[i]  <= opa[i] * opb[i];
				pb_s1[i]  <= opc[i] * opd[i];
				add_s1[i] <= add_v[i];
			end
			wen_s1 <= wen;
			cmd_s1 <= head.cmd;
		end
	end

	always_comb begin
		for (int i = 0; i < MAT_N; i++) begin
			acc[i] = (ACC_W'(pa_s1[i]) + ACC_W'(pb_s1[i]) + ROUND_HALF) >>> FRAC_BITS;
			res[i] = sat_data(acc[i] + ACC_W'(add_s1[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAT_N; i++)
				m_q[i] <= ((i == 0) || (i == 3)) ? FX_ONE : '0;
		end else if (retire && (cmd_s1 != CMD_POINT)) begin
			for (int i = 0; i < MAT_N; i++) begin
				if (wen_s1[i])
					m_q[i] <= res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (retire && (cmd_s1 == CMD_POINT))
			res_valid_q <= 1'b1;
		else if (results.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (retire && (cmd_s1 == CMD_POINT)) begin
			res_x_q <= res[0];
			res_y_q <= res[1];
		end
	end

	assign results.valid = res_valid_q;
	assign results.result_x = res_x_q;
	assign results.result_y = res_y_q;
endmodule

>>> rtl/affine_2d_transform_composer_core.sv
// Top level of the 2D affine transform composer: front end, request queue, back end.
// Depends on aff2d_pkg, aff2d_if, aff2d_front, aff2d_fifo and aff2d_back.
//
//   channel  | direction | handshake   | payload
//   items    | in        | valid/ready | cmd, scale, angle, counterclockwise, shift, point
//   results  | out       | valid/ready | result_x, result_y
//
// After reset the sine table of 2^(ANGLE_BITS-2) entries (1024 by default) is filled,
// one entry a cycle; items.ready stays low until then.
// Transform-point requests stream one per cycle while results.ready stays high.
// A scale, rotate or translate request holds the matrix multiply stage until its
// result is written back, since the next request needs the written-back matrix.
// The result register and the four-entry queue let each side stall on its own.
module affine_2d_transform_composer_core import aff2d_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	aff2d_in_if.sink  items,
	aff2d_out_if.source results
);
	logic         fill_done;
	logic         push_valid;
	queue_entry_t push_entry;
	logic         queue_full;
	logic         queue_empty;
	logic         pop;
	queue_entry_t head;

	aff2d_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.items     (items),
		.queue_full(queue_full),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.fill_done (fill_done)
	);

	aff2d_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_entry(push_entry),
		.full      (queue_full),
		.pop       (pop),
		.head      (head),
		.empty     (queue_empty)
	);

	aff2d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.queue_empty(queue_empty),
		.pop        (pop),
		.results    (results)
	);

	a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		items.ready |-> fill_done)
		else $error("Request taken before the sine table was filled.");

	a_fill_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fill_done |=> fill_done)
		else $error("Sine table fill restarted without a reset.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !queue_empty)
		else $error("Back end issued from an empty queue.");

	a_no_result_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> !results.valid && !push_valid)
		else $error("Work in flight during the sine table fill.");
endmodule
